/* rtl/scfr_pkg.sv */
// Package for the checksummed frame receiver: sizes, codes and the structs
// that pass between its modules. Depends on nothing.
`timescale 1ns / 1ps

package scfr_pkg;

  // Payload bytes per frame.
  localparam int PayloadLen = 40;
  localparam int AddrW      = (PayloadLen > 1) ? $clog2(PayloadLen) : 1;
  localparam int IdxW       = 6;
  localparam int CfgIdxW    = 2;
  localparam int CntW       = 16;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(PayloadLen - 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHeader = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTail   = CfgIdxW'(1);

  localparam logic [7:0] HeaderReset = 8'hA5;
  localparam logic [7:0] TailReset   = 8'h5A;

  // Result kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindFail = 1'b1;

  typedef enum logic [0:0] {
    UOP_EQ  = 1'b0,
    UOP_ADD = 1'b1
  } unit_op_e;

  typedef struct packed {
    unit_op_e   op;
    logic [7:0] a;
    logic [7:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       eq;
  } unit_rsp_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } mem_rd_t;

endpackage

/* rtl/scfr_unit.sv */
// Shared byte unit of the frame receiver: one 8-bit adder and one equality
// compare, selected by the sequencer. Uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_unit (
  input  scfr_pkg::unit_req_t req_i,
  output scfr_pkg::unit_rsp_t rsp_o
);
  import scfr_pkg::*;

  always_comb begin
    rsp_o.sum = 8'h00;
    rsp_o.eq  = 1'b0;
    unique case (req_i.op)
      UOP_ADD: rsp_o.sum = req_i.a + req_i.b;
      UOP_EQ:  rsp_o.eq  = (req_i.a == req_i.b);
      default: rsp_o.eq  = 1'b0;
    endcase
  end

endmodule

/* rtl/scfr_mem.sv */
// Payload store of the frame receiver: one write port and one registered
// read port. Uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_mem (
  input  logic              clk_i,
  input  scfr_pkg::mem_wr_t wr_i,
  input  scfr_pkg::mem_rd_t rd_i,
  output logic [7:0]        rdata_o
);
  import scfr_pkg::*;

  logic [7:0] mem_q [PayloadLen];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sum_checked_frame_receiver.sv */
// Top level of the checksummed frame receiver: sequencer, shared byte unit
// and payload store. Uses scfr_pkg, scfr_unit and scfr_mem.
`timescale 1ns / 1ps

// One received byte per input item. Outside a frame check and the payload
// read-back, the block is ready for a byte: the shared unit compares it with
// the header, adds it to the running sum or compares it with the tail, and a
// checksum byte is stored. After a matching tail, the same unit compares the
// sum with the received checksum. A checksum failure then gives one result and
// the block takes input again once that result has been loaded into the
// output register. A good frame reads its payload back from the store, a
// memory read then an output load per byte, and the input is held off until
// the last byte is loaded. The output register lets the block take new bytes
// while the last result still waits. The store needs no clearing after reset.
module sum_checked_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic [7:0]                   payload_byte_o,
  output logic [scfr_pkg::IdxW-1:0]    payload_index_o,
  output logic                         last_of_run_o,
  output logic [7:0]                   sum_calculated_o,
  output logic [7:0]                   sum_received_o,
  output logic [scfr_pkg::CntW-1:0]    failure_total_o
);
  import scfr_pkg::*;

  typedef enum logic [6:0] {
    ST_HUNT    = 7'b0000001,
    ST_DATA    = 7'b0000010,
    ST_SUM     = 7'b0000100,
    ST_TAIL    = 7'b0001000,
    ST_CHECK   = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WR = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       header_q, tail_q;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       chk_q, chk_d;
  logic [CntW-1:0]  fail_cnt_q, fail_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d;
  logic [7:0]       out_sum_q, out_sum_d;
  logic [7:0]       out_chk_q, out_chk_d;
  logic [CntW-1:0]  out_total_q, out_total_d;

  logic             accept;
  logic             out_free;
  logic             load;
  unit_req_t        unit_req;
  unit_rsp_t        unit_rsp;
  mem_wr_t          mem_wr;
  mem_rd_t          mem_rd;
  logic [7:0]       mem_rdata;

  assign in_ready_o = (state_q == ST_HUNT) || (state_q == ST_DATA) ||
                      (state_q == ST_SUM)  || (state_q == ST_TAIL);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      tail_q   <= TailReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgHeader) begin
        header_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgTail) begin
        tail_q <= cfg_data_i;
      end
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    unit_req = '{op: UOP_EQ, a: rx_byte_i, b: header_q};
    unique case (state_q)
      ST_DATA:  unit_req = '{op: UOP_ADD, a: sum_q, b: rx_byte_i};
      ST_TAIL:  unit_req = '{op: UOP_EQ, a: rx_byte_i, b: tail_q};
      ST_CHECK: unit_req = '{op: UOP_EQ, a: sum_q, b: chk_q};
      default:  unit_req = '{op: UOP_EQ, a: rx_byte_i, b: header_q};
    endcase
  end

  scfr_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  scfr_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    fail_cnt_d  = fail_cnt_q;
    load        = 1'b0;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_sum_d   = out_sum_q;
    out_chk_d   = out_chk_q;
    out_total_d = out_total_q;
    mem_wr      = '{en: 1'b0, addr: pos_q, data: rx_byte_i};
    mem_rd      = '{en: 1'b0, addr: pos_q};

    unique case (state_q)
      ST_HUNT: begin
        if (accept && unit_rsp.eq) begin
          state_d = ST_DATA;
          pos_d   = '0;
          sum_d   = 8'h00;
        end
      end
      ST_DATA: begin
        if (accept) begin
          mem_wr.en = 1'b1;
          sum_d     = unit_rsp.sum;
          if (pos_q == LastAddr) begin
            state_d = ST_SUM;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (accept) begin
          chk_d   = rx_byte_i;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (accept) begin
          state_d = unit_rsp.eq ? ST_CHECK : ST_HUNT;
          pos_d   = '0;
        end
      end
      ST_CHECK: begin
        if (unit_rsp.eq) begin
          state_d = ST_EMIT_RD;
          pos_d   = '0;
        end else if (out_free) begin
          load        = 1'b1;
          fail_cnt_d  = fail_cnt_q + 1'b1;
          out_kind_d  = KindFail;
          out_byte_d  = 8'h00;
          out_idx_d   = '0;
          out_last_d  = 1'b1;
          out_sum_d   = sum_q;
          out_chk_d   = chk_q;
          out_total_d = fail_cnt_q + 1'b1;
          state_d     = ST_HUNT;
        end
      end
      ST_EMIT_RD: begin
        mem_rd.en = 1'b1;
        state_d   = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          load        = 1'b1;
          out_kind_d  = KindData;
          out_byte_d  = mem_rdata;
          out_idx_d   = IdxW'(pos_q);
          out_last_d  = (pos_q == LastAddr);
          out_sum_d   = sum_q;
          out_chk_d   = chk_q;
          out_total_d = fail_cnt_q;
          if (pos_q == LastAddr) begin
            state_d = ST_HUNT;
            pos_d   = '0;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      pos_q       <= '0;
      sum_q       <= 8'h00;
      chk_q       <= 8'h00;
      fail_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      chk_q       <= chk_d;
      fail_cnt_q  <= fail_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= out_kind_d;
      out_byte_q  <= out_byte_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
      out_sum_q   <= out_sum_d;
      out_chk_q   <= out_chk_d;
      out_total_q <= out_total_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign payload_byte_o   = out_byte_q;
  assign payload_index_o  = out_idx_q;
  assign last_of_run_o    = out_last_q;
  assign sum_calculated_o = out_sum_q;
  assign sum_received_o   = out_chk_q;
  assign failure_total_o  = out_total_q;

`ifndef SYNTH
  a_fail_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fail_cnt_q) |-> fail_cnt_q == CntW'($past(fail_cnt_q) + 1'b1))
    else $error("failure count moved by other than one");

  a_fail_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KindFail) |-> sum_calculated_o != sum_received_o)
    else $error("failure item reported with matching sums");

  a_data_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KindData) |-> sum_calculated_o == sum_received_o)
    else $error("payload item reported with mismatching sums");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KindData && last_of_run_o) |->
      payload_index_o == IdxW'(PayloadLen - 1))
    else $error("last payload item at wrong index");
`endif

endmodule

/* bench/sum_checked_frame_receiver_checker.sv */
// Checker for the checksummed frame receiver: watches the byte, result and
// configuration ports, predicts the deframed results and compares them.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         result_kind_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic [scfr_pkg::IdxW-1:0]    payload_index_i,
  input  logic                         last_of_run_i,
  input  logic [7:0]                   sum_calculated_i,
  input  logic [7:0]                   sum_received_i,
  input  logic [scfr_pkg::CntW-1:0]    failure_total_i,
  output int                           fail_count_o,
  output int                           backlog_o
);
  import scfr_pkg::*;

  localparam int MaxPrinted = 30;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_DATA,
    RX_SUM,
    RX_TAIL
  } rx_phase_e;

  typedef struct packed {
    logic            kind;
    logic [7:0]      data;
    logic [IdxW-1:0] idx;
    logic            last;
    logic [7:0]      sum_calc;
    logic [7:0]      sum_rx;
    logic [CntW-1:0] fails;
  } frame_result_t;

  rx_phase_e       phase_q;
  logic [IdxW-1:0] pos_q;
  logic [7:0]      payload_q [PayloadLen];
  logic [7:0]      csum_q;
  logic [7:0]      sum_q;
  logic [7:0]      header_q;
  logic [7:0]      tail_q;
  logic [CntW-1:0] fails_q;
  frame_result_t   frame_results_q [$];

  initial fail_count_o = 0;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxPrinted) begin
      $display("%0t frame checker: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Advances the predicted receiver by one byte and queues what it emits.
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    case (phase_q)
      RX_HUNT: begin
        if (b == header_q) begin
          phase_q = RX_DATA;
          pos_q   = '0;
          sum_q   = '0;
        end
      end
      RX_DATA: begin
        if (pos_q < PayloadLen) payload_q[pos_q] = b;
        sum_q = sum_q + b;
        pos_q = pos_q + 1'b1;
        if (pos_q == '0 || pos_q >= PayloadLen) phase_q = RX_SUM;
      end
      RX_SUM: begin
        csum_q  = b;
        phase_q = RX_TAIL;
      end
      default: begin
        if (b == tail_q) begin
          r.sum_calc = sum_q;
          r.sum_rx   = csum_q;
          if (sum_q == csum_q) begin
            r.kind  = KindData;
            r.fails = fails_q;
            for (int i = 0; i < PayloadLen; i++) begin
              r.data = payload_q[i];
              r.idx  = IdxW'(i);
              r.last = (i == PayloadLen - 1);
              frame_results_q.push_back(r);
            end
          end else begin
            fails_q = fails_q + 1'b1;
            r.kind  = KindFail;
            r.data  = '0;
            r.idx   = '0;
            r.last  = 1'b1;
            r.fails = fails_q;
            frame_results_q.push_back(r);
          end
        end
        phase_q = RX_HUNT;
        pos_q   = '0;
      end
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result item arrived with nothing expected");
      return;
    end
    want = frame_results_q.pop_front();
    compare_field("result_kind", 16'(result_kind_i), 16'(want.kind));
    compare_field("payload_byte", 16'(payload_byte_i), 16'(want.data));
    compare_field("payload_index", 16'(payload_index_i), 16'(want.idx));
    compare_field("last_of_run", 16'(last_of_run_i), 16'(want.last));
    compare_field("sum_calculated", 16'(sum_calculated_i), 16'(want.sum_calc));
    compare_field("sum_received", 16'(sum_received_i), 16'(want.sum_rx));
    compare_field("failure_total", failure_total_i, want.fails);
  endtask

  // Results are compared before the byte of the same edge is absorbed, since
  // no result can come from a byte in the cycle it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  = RX_HUNT;
      pos_q    = '0;
      csum_q   = '0;
      sum_q    = '0;
      fails_q  = '0;
      header_q = HeaderReset;
      tail_q   = TailReset;
      frame_results_q.delete();
      backlog_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeader: header_q = cfg_data_i;
          CfgTail:   tail_q   = cfg_data_i;
          default:   ;
        endcase
      end
      if (in_valid_i && in_ready_i) deframe_byte(rx_byte_i);
      backlog_o <= frame_results_q.size();
    end
  end

endmodule

/* bench/sum_checked_frame_receiver_tb.sv */
// Testbench top for the checksummed frame receiver: clock, reset, byte and
// register stimulus, output back-pressure and the verdict.
// Depends on scfr_pkg, the receiver RTL and sum_checked_frame_receiver_checker.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_tb;
  import scfr_pkg::*;

  localparam int SettleCycles = 2 * PayloadLen + 20;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgTail + 1'b1;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TAIL
  } frame_shape_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_MARKERS
  } payload_fill_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic               result_kind;
  logic [7:0]         payload_byte;
  logic [IdxW-1:0]    payload_index;
  logic               last_of_run;
  logic [7:0]         sum_calculated;
  logic [7:0]         sum_received;
  logic [CntW-1:0]    failure_total;
  int                 fail_count;
  int                 backlog;

  logic       calm;
  int         gap_odds;
  int         stall_odds;
  logic [7:0] cur_header;
  logic [7:0] cur_tail;

  sum_checked_frame_receiver dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_kind_o   (result_kind),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .last_of_run_o   (last_of_run),
    .sum_calculated_o(sum_calculated),
    .sum_received_o  (sum_received),
    .failure_total_o (failure_total)
  );

  sum_checked_frame_receiver_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .result_kind_i   (result_kind),
    .payload_byte_i  (payload_byte),
    .payload_index_i (payload_index),
    .last_of_run_i   (last_of_run),
    .sum_calculated_i(sum_calculated),
    .sum_received_i  (sum_received),
    .failure_total_i (failure_total),
    .fail_count_o    (fail_count),
    .backlog_o       (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("sum_checked_frame_receiver regression: fail");
    $finish;
  end

  // Result side: stall bursts whose density changes now and then.
  initial begin
    out_ready  = 1'b0;
    stall_odds = 2;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 127) == 0) stall_odds = $urandom_range(0, 4);
      if (!calm && $urandom_range(0, 15) < stall_odds) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CfgHeader: cur_header = value;
      CfgTail:   cur_tail   = value;
      default:   ;
    endcase
  endtask

  // Waits until every predicted result has been taken and the block is quiet.
  task automatic drain();
    in_valid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_frame(input frame_shape_e shape, input payload_fill_e fill);
    logic [7:0] body [PayloadLen];
    logic [7:0] total;
    logic [7:0] csum;
    logic [7:0] closing;
    total = '0;
    for (int i = 0; i < PayloadLen; i++) begin
      case (fill)
        FILL_ZERO: body[i] = 8'h00;
        FILL_ONES: body[i] = 8'hFF;
        default:   body[i] = 8'($urandom_range(0, 255));
      endcase
    end
    if (fill == FILL_MARKERS) begin
      body[0] = 8'h00;
      body[1] = 8'hFF;
      body[2] = cur_header;
      body[3] = cur_tail;
    end
    for (int i = 0; i < PayloadLen; i++) total = total + body[i];
    csum    = (shape == FRAME_BAD_SUM) ? 8'(total + $urandom_range(1, 255)) : total;
    closing = (shape == FRAME_BAD_TAIL) ? (cur_tail ^ 8'($urandom_range(1, 255))) : cur_tail;
    send_byte(cur_header);
    for (int i = 0; i < PayloadLen; i++) send_byte(body[i]);
    send_byte(csum);
    send_byte(closing);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CfgHeader;
    cfg_data    = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    calm        = 1'b0;
    gap_odds    = 2;
    cur_header  = HeaderReset;
    cur_tail    = TailReset;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Writes to indexes past the register list must leave both registers alone.
    write_reg(CfgFirstUnused, 8'h00);
    write_reg(CfgFirstUnused + 1'b1, 8'hFF);

    // Bytes seen while hunting, the tail value among them, are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_tail);
    send_frame(FRAME_GOOD, FILL_MARKERS);
    send_frame(FRAME_BAD_TAIL, FILL_RANDOM);
    drain();

    // The last frame carries the new header and tail values as plain data.
    write_reg(CfgHeader, 8'h00);
    write_reg(CfgTail, 8'hFF);
    calm = 1'b1;
    send_frame(FRAME_BAD_SUM, FILL_MARKERS);

    drain();
    if (fail_count == 0) begin
      $display("sum_checked_frame_receiver regression: pass");
    end else begin
      $display("sum_checked_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
